### src/fault_cluster_bit_aggregator_macros.svh
// assertion macros for the fault cluster bit aggregator
// used by the top level only, no other dependencies
`ifndef FAULT_CLUSTER_BIT_AGGREGATOR_MACROS_SVH
`define FAULT_CLUSTER_BIT_AGGREGATOR_MACROS_SVH

// property checked only while out of reset
`define FCBA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fcba assertion failed");

// property checked on every edge, reset included
`define FCBA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fcba assertion failed");

`endif

### src/fcba_pkg.sv
// shared types and constants of the fault cluster bit aggregator
// no dependencies
`default_nettype none

package fcba_pkg;

  localparam int unsigned NUM_CLUSTERS_DEF = 60;
  localparam int unsigned FAULT_SLOTS_DEF  = 256;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned OBJ_W = 8;
  localparam int unsigned ST_W  = 8;
  localparam int unsigned CL_W  = 6;
  localparam int unsigned BIT_W = 3;
  localparam int unsigned CV_W  = 8;
  // id*100+obj stays below 2^23
  localparam int unsigned KEY_W = 23;

  localparam int unsigned KEY_MULT = 100;
  localparam logic [ST_W-1:0] FAULT_ACTIVE = 8'd1;
  localparam logic [CV_W-1:0] CV_EMPTY = 8'h00;

  typedef struct packed {
    logic [ID_W-1:0]  fault_id;
    logic [OBJ_W-1:0] fault_obj;
    logic [ST_W-1:0]  fault_status;
    logic             has_cluster;
    logic [CL_W-1:0]  cluster_index;
    logic [BIT_W-1:0] bit_position;
    logic             last_of_event;
  } in_item_t;

  typedef struct packed {
    logic [CL_W-1:0]  cluster_number;
    logic [CV_W-1:0]  cluster_value;
    logic [ID_W-1:0]  event_fault_id;
    logic [OBJ_W-1:0] event_fault_obj;
    logic [ST_W-1:0]  event_status;
    logic             dropped_insert;
    logic             last_item;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [CL_W-1:0]  cluster;
    logic [KEY_W-1:0] key;
    logic [BIT_W-1:0] bitpos;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_SNAP_RD,
    ST_SNAP_LD
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic update;
    logic snap_rd;
    logic snap_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic snap_done;
    logic in_upd;
    logic in_last;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### src/fcba_ctrl.sv
// controller state machine of the fault cluster bit aggregator
// depends on fcba_pkg
`default_nettype none

module fcba_ctrl
  import fcba_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.in_upd) begin
            state_nxt = ST_SCAN;
          end else if (st.in_last) begin
            state_nxt = ST_SNAP_RD;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = st.last ? ST_SNAP_RD : ST_IDLE;
      end
      ST_SNAP_RD: begin
        cmd.snap_rd = 1'b1;
        state_nxt   = ST_SNAP_LD;
      end
      ST_SNAP_LD: begin
        if (st.out_free) begin
          cmd.snap_ld = 1'b1;
          state_nxt   = st.snap_done ? ST_IDLE : ST_SNAP_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/fcba_dp.sv
// datapath: entry table, cluster value store, scan accumulators, output register
// depends on fcba_pkg
`default_nettype none

module fcba_dp
  import fcba_pkg::*;
#(
  parameter int unsigned NUM_CLUSTERS = NUM_CLUSTERS_DEF,
  parameter int unsigned FAULT_SLOTS  = FAULT_SLOTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cmd_t     cmd,
  output status_t       st,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int unsigned CLR_CNT = (FAULT_SLOTS > NUM_CLUSTERS) ? FAULT_SLOTS : NUM_CLUSTERS;
  localparam int unsigned CNT_W   = $clog2(CLR_CNT + 1);
  localparam int unsigned SIDX_W  = $clog2(FAULT_SLOTS);
  localparam int unsigned CIDX_W  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;

  entry_t          ent_mem [FAULT_SLOTS];
  logic [CV_W-1:0] clu_mem [NUM_CLUSTERS];

  logic [CNT_W-1:0]  cnt_r;
  logic              rd_vld_r;
  logic [SIDX_W-1:0] rd_idx_r;
  entry_t            ent_rd_r;
  logic [CV_W-1:0]   clu_rd_r;

  logic [ID_W-1:0]   id_r;
  logic [OBJ_W-1:0]  obj_r;
  logic [ST_W-1:0]   status_r;
  logic [CL_W-1:0]   cidx_r;
  logic [BIT_W-1:0]  bit_r;
  logic [KEY_W-1:0]  key_r;
  logic              last_r;

  logic              found_r;
  logic [SIDX_W-1:0] match_idx_r;
  logic              free_r;
  logic [SIDX_W-1:0] free_idx_r;
  logic [CV_W-1:0]   or_all_r;
  logic [CV_W-1:0]   or_other_r;

  logic              drop_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              scan_issue;
  logic              in_cl;
  logic              hit;
  logic [CV_W-1:0]   ent_mask;
  logic              stat_on;
  logic [CV_W-1:0]   new_value;
  logic              do_insert;
  logic              do_remove;
  logic              do_drop;

  assign scan_issue = cmd.scan && (cnt_r < CNT_W'(FAULT_SLOTS));
  assign in_cl      = ent_rd_r.valid && (ent_rd_r.cluster == cidx_r);
  assign hit        = in_cl && (ent_rd_r.key == key_r);
  assign ent_mask   = CV_W'(1) << ent_rd_r.bitpos;
  assign stat_on    = (status_r == FAULT_ACTIVE);

  // decide the table change and rebuilt cluster value from the scan results
  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_drop   = 1'b0;
    new_value = or_all_r;
    if (found_r) begin
      if (!stat_on) begin
        do_remove = 1'b1;
        new_value = or_other_r;
      end
    end else if (stat_on) begin
      if (free_r) begin
        do_insert = 1'b1;
        new_value = or_all_r | (CV_W'(1) << bit_r);
      end else begin
        do_drop = 1'b1;
      end
    end
  end

  // address counter shared by clearing pass, scan and snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load || cmd.update) begin
      cnt_r <= '0;
    end else if (cmd.clr || scan_issue || cmd.snap_ld) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
    end
  end

  // entry table port
  always_ff @(posedge clk) begin
    if (cmd.clr && (cnt_r < CNT_W'(FAULT_SLOTS))) begin
      ent_mem[cnt_r[SIDX_W-1:0]] <= '0;
    end else if (cmd.update && do_remove) begin
      ent_mem[match_idx_r] <= '0;
    end else if (cmd.update && do_insert) begin
      ent_mem[free_idx_r] <= '{valid: 1'b1, cluster: cidx_r, key: key_r, bitpos: bit_r};
    end
    if (scan_issue) begin
      ent_rd_r <= ent_mem[cnt_r[SIDX_W-1:0]];
      rd_idx_r <= cnt_r[SIDX_W-1:0];
    end
  end

  // cluster value store
  always_ff @(posedge clk) begin
    if (cmd.clr && (cnt_r < CNT_W'(NUM_CLUSTERS))) begin
      clu_mem[cnt_r[CIDX_W-1:0]] <= CV_EMPTY;
    end else if (cmd.update) begin
      clu_mem[cidx_r[CIDX_W-1:0]] <= new_value;
    end
    if (cmd.snap_rd) begin
      clu_rd_r <= clu_mem[cnt_r[CIDX_W-1:0]];
    end
  end

  // input capture, key formed on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r     <= in_data.fault_id;
      obj_r    <= in_data.fault_obj;
      status_r <= in_data.fault_status;
      cidx_r   <= in_data.cluster_index;
      bit_r    <= in_data.bit_position;
      key_r    <= KEY_W'(in_data.fault_id) * KEY_W'(KEY_MULT) + KEY_W'(in_data.fault_obj);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (cmd.load) begin
      last_r <= in_data.last_of_event;
    end
  end

  // scan accumulators: first hit, first free slot, value with and without the hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (rd_vld_r) begin
      if (hit && !found_r) begin
        found_r <= 1'b1;
      end
      if (!ent_rd_r.valid && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      or_all_r   <= CV_EMPTY;
      or_other_r <= CV_EMPTY;
    end else if (rd_vld_r) begin
      if (hit && !found_r) begin
        match_idx_r <= rd_idx_r;
      end
      if (!ent_rd_r.valid && !free_r) begin
        free_idx_r <= rd_idx_r;
      end
      if (in_cl) begin
        or_all_r <= or_all_r | ent_mask;
      end
      if (in_cl && !hit) begin
        or_other_r <= or_other_r | ent_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= 1'b0;
    end else if (cmd.update && do_drop) begin
      drop_r <= 1'b1;
    end else if (cmd.snap_ld && st.snap_done) begin
      drop_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.snap_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap_ld) begin
      out_data_r.cluster_number  <= CL_W'(cnt_r);
      out_data_r.cluster_value   <= clu_rd_r;
      out_data_r.event_fault_id  <= id_r;
      out_data_r.event_fault_obj <= obj_r;
      out_data_r.event_status    <= status_r;
      out_data_r.dropped_insert  <= drop_r;
      out_data_r.last_item       <= st.snap_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // cluster index compared one bit wider so a full 64-cluster setup stays valid
  always_comb begin
    st.clr_done  = (cnt_r == CNT_W'(CLR_CNT - 1));
    st.scan_done = rd_vld_r && (rd_idx_r == SIDX_W'(FAULT_SLOTS - 1));
    st.snap_done = (cnt_r == CNT_W'(NUM_CLUSTERS - 1));
    st.in_upd    = in_data.has_cluster &&
                   ({1'b0, in_data.cluster_index} < (CL_W+1)'(NUM_CLUSTERS));
    st.in_last   = in_data.last_of_event;
    st.last      = last_r;
    st.out_free  = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

### src/fault_cluster_bit_aggregator.sv
// Fault cluster bit aggregator. After reset the block clears its entry table and cluster
// values with in_ready low. A membership with has_cluster set and a known cluster adds
// a scan of the entry table (one single-port table read per cycle) and an update step.
// A membership with last_of_event set is followed by NUM_CLUSTERS snapshot items, paced
// by the cluster value store read and held back while the output register is still full.
// The next membership is taken while the last snapshot item still waits in the output
// register.
// depends on fcba_pkg, fcba_ctrl, fcba_dp and fault_cluster_bit_aggregator_macros.svh
`default_nettype none

`include "fault_cluster_bit_aggregator_macros.svh"

module fault_cluster_bit_aggregator
  import fcba_pkg::*;
#(
  parameter int unsigned NUM_CLUSTERS = NUM_CLUSTERS_DEF,
  parameter int unsigned FAULT_SLOTS  = FAULT_SLOTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  cmd_t    cmd;
  status_t st;

  fcba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fcba_dp #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .FAULT_SLOTS  (FAULT_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the clearing pass holds off input transfers
  `FCBA_ASSERT_ALWAYS(a_clear_blocks_input, clk, !rst_n |=> !in_ready)
  // a snapshot item never overwrites one still waiting
  `FCBA_ASSERT(a_no_overwrite, clk, rst_n, cmd.snap_ld |-> (!out_valid || out_ready))
  // a last membership that updates nothing goes straight to the snapshot
  `FCBA_ASSERT(a_direct_snapshot, clk, rst_n,
    (in_valid && in_ready && in_data.last_of_event && !st.in_upd) |=> cmd.snap_rd)

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for fault_cluster_bit_aggregator: drives fault memberships and
// checks every snapshot item against a behavioral model of the cluster entry table.
// Depends on fcba_pkg and the fault_cluster_bit_aggregator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcba_pkg::*;

  localparam int NCL = NUM_CLUSTERS_DEF;
  localparam int NSLOTS = FAULT_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 280;
  localparam int MAX_ITEMS = 700;
  localparam int DRAIN_CYCLES = 400;

  // model of the entry table and cluster values; holds the snapshot items still due
  class cluster_value_predictor;
    bit              slot_valid[NSLOTS];
    bit [CL_W-1:0]   slot_cluster[NSLOTS];
    bit [31:0]       slot_key[NSLOTS];
    bit [BIT_W-1:0]  slot_bit[NSLOTS];
    // source fields kept so stimulus can hit an existing key again
    bit [ID_W-1:0]   slot_id[NSLOTS];
    bit [OBJ_W-1:0]  slot_obj[NSLOTS];
    bit [CV_W-1:0]   cluster_val[NCL];
    bit              drop_pending;
    int              drop_total;
    int              errors;
    out_item_t       snapshot_q[$];

    function void note_membership(in_item_t m);
      bit [31:0] key;
      bit [CV_W-1:0] v;
      int found;
      int free_slot;
      out_item_t r;
      key = {16'h0, m.fault_id} * 32'd100 + {24'h0, m.fault_obj};
      if (m.has_cluster && m.cluster_index < NCL) begin
        found = -1;
        free_slot = -1;
        for (int i = 0; i < NSLOTS; i++) begin
          if (found < 0 && slot_valid[i] && slot_cluster[i] == m.cluster_index &&
              slot_key[i] == key)
            found = i;
          if (free_slot < 0 && !slot_valid[i])
            free_slot = i;
        end
        if (found >= 0) begin
          if (m.fault_status != FAULT_ACTIVE)
            slot_valid[found] = 1'b0;
        end else if (m.fault_status == FAULT_ACTIVE) begin
          if (free_slot >= 0) begin
            slot_valid[free_slot] = 1'b1;
            slot_cluster[free_slot] = m.cluster_index;
            slot_key[free_slot] = key;
            slot_bit[free_slot] = m.bit_position;
            slot_id[free_slot] = m.fault_id;
            slot_obj[free_slot] = m.fault_obj;
          end else begin
            drop_pending = 1'b1;
            drop_total++;
          end
        end
        v = CV_EMPTY;
        for (int i = 0; i < NSLOTS; i++)
          if (slot_valid[i] && slot_cluster[i] == m.cluster_index)
            v[slot_bit[i]] = 1'b1;
        cluster_val[m.cluster_index] = v;
      end
      if (m.last_of_event) begin
        for (int k = 0; k < NCL; k++) begin
          r.cluster_number = CL_W'(k);
          r.cluster_value = cluster_val[k];
          r.event_fault_id = m.fault_id;
          r.event_fault_obj = m.fault_obj;
          r.event_status = m.fault_status;
          r.dropped_insert = drop_pending;
          r.last_item = (k == NCL - 1);
          snapshot_q.push_back(r);
        end
        drop_pending = 1'b0;
      end
    endfunction

    function void report(string field, logic [31:0] e, logic [31:0] a);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
    endfunction

    function void check_snapshot_item(out_item_t a);
      out_item_t e;
      if (snapshot_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected snapshot item, expected none, actual %h", $time, a);
        return;
      end
      e = snapshot_q.pop_front();
      if (a.cluster_number !== e.cluster_number)
        report("cluster_number", e.cluster_number, a.cluster_number);
      if (a.cluster_value !== e.cluster_value)
        report("cluster_value", e.cluster_value, a.cluster_value);
      if (a.event_fault_id !== e.event_fault_id)
        report("event_fault_id", e.event_fault_id, a.event_fault_id);
      if (a.event_fault_obj !== e.event_fault_obj)
        report("event_fault_obj", e.event_fault_obj, a.event_fault_obj);
      if (a.event_status !== e.event_status)
        report("event_status", e.event_status, a.event_status);
      if (a.dropped_insert !== e.dropped_insert)
        report("dropped_insert", e.dropped_insert, a.dropped_insert);
      if (a.last_item !== e.last_item)
        report("last_item", e.last_item, a.last_item);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  cluster_value_predictor clusters;
  bit steady = 1'b0;
  int counted = 0;
  int mixed_items = 0;

  fault_cluster_bit_aggregator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      clusters.check_snapshot_item(out_data);
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic in_item_t membership(bit [15:0] id, bit [7:0] obj, bit [7:0] st,
                                          bit has, bit [5:0] idx, bit [2:0] bpos, bit last);
    in_item_t m;
    m.fault_id = id;
    m.fault_obj = obj;
    m.fault_status = st;
    m.has_cluster = has;
    m.cluster_index = idx;
    m.bit_position = bpos;
    m.last_of_event = last;
    return m;
  endfunction

  // called right after reset release or right after a transfer
  task automatic send_membership(in_item_t m);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (in_ready !== 1'b1);
    clusters.note_membership(m);
  endtask

  function automatic int pick_active_slot();
    int start;
    int s;
    start = $urandom_range(0, NSLOTS - 1);
    for (int i = 0; i < NSLOTS; i++) begin
      s = (start + i) % NSLOTS;
      if (clusters.slot_valid[s])
        return s;
    end
    return -1;
  endfunction

  // one fault event: shared id/obj/status over 1..4 cluster memberships
  task automatic random_event(bit fill);
    in_item_t m;
    int n;
    int roll;
    int pick;
    bit reuse;
    m = '0;
    n = $urandom_range(1, 4);
    roll = $urandom_range(0, 99);
    pick = fill ? -1 : pick_active_slot();
    reuse = 1'b0;
    m.fault_id = 16'($urandom);
    m.fault_obj = 8'($urandom);
    m.fault_status = FAULT_ACTIVE;
    if (pick >= 0 && roll < 45) begin
      reuse = 1'b1;
      m.fault_id = clusters.slot_id[pick];
      m.fault_obj = clusters.slot_obj[pick];
      // same key reached through another id/obj pair
      if (m.fault_obj >= 100 && m.fault_id != 16'hffff && $urandom_range(0, 3) == 0) begin
        m.fault_id = m.fault_id + 16'd1;
        m.fault_obj = m.fault_obj - 8'd100;
      end
      if (roll < 35) begin
        m.fault_status = 8'($urandom);
        if (m.fault_status == FAULT_ACTIVE)
          m.fault_status = 8'h00;
      end
    end else if (roll >= (fill ? 95 : 88)) begin
      m.fault_status = 8'($urandom);
    end
    for (int j = 0; j < n; j++) begin
      m.has_cluster = ($urandom_range(0, 99) >= 5);
      if ($urandom_range(0, 99) < 6)
        m.cluster_index = 6'($urandom_range(NCL, 63));
      else
        m.cluster_index = 6'($urandom_range(0, NCL - 1));
      if (reuse && j == 0) begin
        m.has_cluster = 1'b1;
        m.cluster_index = clusters.slot_cluster[pick];
      end
      m.bit_position = 3'($urandom);
      // a few broken events run into the next one without a last flag
      m.last_of_event = (j == n - 1) && ($urandom_range(0, 99) >= 5);
      if ((m.has_cluster && m.cluster_index < NCL) || m.last_of_event) begin
        counted++;
        if (!fill)
          mixed_items++;
      end
      send_membership(m);
    end
  endtask

  initial begin
    in_item_t directed[$];
    clusters = new;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes and the first snapshot
    directed.push_back(membership(16'h0000, 8'h00, FAULT_ACTIVE, 1'b1, 6'd0, 3'd0, 1'b1));
    directed.push_back(membership(16'hffff, 8'hff, FAULT_ACTIVE, 1'b1, 6'd59, 3'd7, 1'b0));
    // repeat of an active key, bit ignored
    directed.push_back(membership(16'hffff, 8'hff, FAULT_ACTIVE, 1'b1, 6'd59, 3'd3, 1'b0));
    // unknown clusters and no cluster
    directed.push_back(membership(16'h00aa, 8'h55, FAULT_ACTIVE, 1'b1, 6'd60, 3'd1, 1'b0));
    directed.push_back(membership(16'h5555, 8'haa, FAULT_ACTIVE, 1'b1, 6'd63, 3'd7, 1'b1));
    directed.push_back(membership(16'h1234, 8'h56, FAULT_ACTIVE, 1'b0, 6'd5, 3'd2, 1'b1));
    // clear of a key that was never inserted
    directed.push_back(membership(16'h1234, 8'h05, 8'h00, 1'b1, 6'd5, 3'd4, 1'b0));
    // id 1 obj 0 and id 0 obj 100 share one key
    directed.push_back(membership(16'h0001, 8'h00, FAULT_ACTIVE, 1'b1, 6'd10, 3'd2, 1'b0));
    directed.push_back(membership(16'h0000, 8'd100, 8'h00, 1'b1, 6'd10, 3'd2, 1'b1));
    // same key in two clusters, cleared in one only
    directed.push_back(membership(16'h0007, 8'h07, FAULT_ACTIVE, 1'b1, 6'd20, 3'd1, 1'b0));
    directed.push_back(membership(16'h0007, 8'h07, FAULT_ACTIVE, 1'b1, 6'd21, 3'd6, 1'b0));
    directed.push_back(membership(16'h0007, 8'h07, 8'hff, 1'b1, 6'd20, 3'd1, 1'b1));
    // clear with a status other than zero
    directed.push_back(membership(16'hffff, 8'hff, 8'h02, 1'b1, 6'd59, 3'd0, 1'b1));
    // several bits in one cluster, middle one cleared
    directed.push_back(membership(16'h0100, 8'h01, FAULT_ACTIVE, 1'b1, 6'd30, 3'd0, 1'b0));
    directed.push_back(membership(16'h0100, 8'h02, FAULT_ACTIVE, 1'b1, 6'd30, 3'd4, 1'b0));
    directed.push_back(membership(16'h0100, 8'h03, FAULT_ACTIVE, 1'b1, 6'd30, 3'd7, 1'b0));
    directed.push_back(membership(16'h0100, 8'h02, 8'h80, 1'b1, 6'd30, 3'd4, 1'b1));
    // two keys on the same bit, one cleared leaves the bit set
    directed.push_back(membership(16'h0200, 8'h10, FAULT_ACTIVE, 1'b1, 6'd31, 3'd5, 1'b0));
    directed.push_back(membership(16'h0201, 8'h10, FAULT_ACTIVE, 1'b1, 6'd31, 3'd5, 1'b0));
    directed.push_back(membership(16'h0200, 8'h10, 8'hfe, 1'b1, 6'd31, 3'd5, 1'b1));
    foreach (directed[i])
      send_membership(directed[i]);

    // fill the table until inserts get dropped, then mix clears and refills
    while (!(counted >= RANDOM_ITEMS && clusters.drop_total >= 3 && mixed_items >= 60) &&
           counted < MAX_ITEMS) begin
      steady = (counted >= 40 && counted < 100);
      random_event(clusters.drop_total < 3);
    end
    steady = 1'b0;
    // close any event left open by a broken sequence
    send_membership(membership(16'($urandom), 8'($urandom), 8'($urandom), 1'b0, 6'd0,
                               3'd0, 1'b1));
    @(negedge clk);
    in_valid <= 1'b0;

    while (clusters.snapshot_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (clusters.errors == 0 && clusters.snapshot_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
